// ===== hw/rtl/gdd_pkg.sv =====
`default_nettype none

package gdd_pkg;

  localparam int unsigned MAX_BLOCK_LENGTH_DEF = 1024;
  localparam int unsigned SAMPLE_WIDTH_DEF     = 16;
  localparam int unsigned ACCUM_WIDTH_DEF      = 40;

  localparam int unsigned NUM_BINS   = 8;
  localparam int unsigned COEFF_W    = 16;
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned POWER_W    = 64;
  localparam int unsigned BLEN_W     = 11;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned MAX_IMPURE = 3;

  // twist / purity scale factors, per mille
  localparam int unsigned K_ONE = 1000;
  localparam int unsigned K_ROW = 158;
  localparam int unsigned K_COL = 398;
  localparam int unsigned K_W   = 10;

  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COEFFS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COL_COEFFS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_LEN   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_POWER_THR   = 2'd3;

  localparam logic [BLEN_W-1:0]  BLOCK_LEN_RESET = 11'd205;
  localparam logic [POWER_W-1:0] POWER_THR_RESET = 64'd4000000000;

  typedef struct packed {
    logic [63:0]         row_coeffs;
    logic [63:0]         col_coeffs;
    logic [BLEN_W-1:0]   block_length;
    logic [POWER_W-1:0]  power_threshold;
  } cfg_t;

  function automatic logic signed [COEFF_W-1:0] coeff_of(input logic [63:0] row,
                                                         input logic [63:0] col,
                                                         input logic [2:0]  bin);
    logic [63:0] r;
    r = bin[2] ? col : row;
    return r[COEFF_W*bin[1:0] +: COEFF_W];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gdd_front.sv =====
`default_nettype none

module gdd_front #(
  parameter int unsigned SAMPLE_WIDTH = gdd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    sample_valid_i,
  output logic                         sample_ready_o,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                         q_valid_o,
  input  wire logic                    q_ready_i,
  output logic [SAMPLE_WIDTH-1:0]      q_sample_o
);

  localparam int unsigned PTR_W = $clog2(gdd_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(gdd_pkg::QDEPTH + 1);

  logic [SAMPLE_WIDTH-1:0] mem_q [gdd_pkg::QDEPTH];
  logic [PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    push, pop;

  assign sample_ready_o = (cnt_q != CNT_W'(gdd_pkg::QDEPTH));
  assign q_valid_o      = (cnt_q != '0);
  assign q_sample_o     = mem_q[rd_ptr_q];
  assign push           = sample_valid_i && sample_ready_o;
  assign pop            = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= sample_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gdd_back.sv =====
`default_nettype none

module gdd_back #(
  parameter int unsigned MAX_BLOCK_LENGTH = gdd_pkg::MAX_BLOCK_LENGTH_DEF,
  parameter int unsigned SAMPLE_WIDTH     = gdd_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned ACCUM_WIDTH      = gdd_pkg::ACCUM_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire gdd_pkg::cfg_t           cfg_i,
  input  wire logic                    q_valid_i,
  output logic                         q_ready_o,
  input  wire logic [SAMPLE_WIDTH-1:0] q_sample_i,
  output logic                         result_valid_o,
  input  wire logic                    result_ready_i,
  output logic [1:0]                   row_index_o,
  output logic [1:0]                   col_index_o,
  output logic [63:0]                  row_power_o,
  output logic [63:0]                  col_power_o,
  output logic                         detected_o
);

  localparam int unsigned A      = ACCUM_WIDTH;
  localparam int unsigned CW     = gdd_pkg::COEFF_W;
  localparam int unsigned PW     = gdd_pkg::POWER_W;
  localparam int unsigned CQ_W   = CW + A;
  localparam int unsigned PROD_W = CW + 2 * A;
  localparam int unsigned SW     = PROD_W + 1;
  localparam int unsigned NSTEP  = (A + 7) / 8;
  localparam int unsigned STEP_W = $clog2(NSTEP);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > gdd_pkg::BLEN_W) ? CNT_W : gdd_pkg::BLEN_W;
  localparam int unsigned KP_W   = PW + gdd_pkg::K_W;
  localparam int unsigned FB     = gdd_pkg::FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_REC  = 4'd1;
  localparam logic [3:0] S_PLD  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_FIN  = 4'd4;
  localparam logic [3:0] S_TST1 = 4'd5;
  localparam logic [3:0] S_TST2 = 4'd6;
  localparam logic [3:0] S_PUR  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]          state_q;
  logic [2:0]          bin_q;
  logic [1:0]          ph_q;
  logic [STEP_W-1:0]   step_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [A-1:0]        d1_q [gdd_pkg::NUM_BINS];
  logic [A-1:0]        d2_q [gdd_pkg::NUM_BINS];
  logic [A-1:0]        x_q;
  logic [A-1:0]        m2_q;
  logic [CQ_W-1:0]     cq_q;
  logic                neg_q;
  logic [PROD_W-1:0]   mul_a_q, acc_q;
  logic [A-1:0]        mul_b_q;
  logic [SW-1:0]       s_q;
  logic [PROD_W-1:0]   t_q;
  logic [PW-1:0]       pw_q [gdd_pkg::NUM_BINS];
  logic [PW-1:0]       rp_q, cp_q;
  logic [1:0]          ri_q, ci_q;
  logic [KP_W-1:0]     a1_q, b1_q, a2_q, b2_q, pm_q;
  logic                det_q;
  logic [3:0]          imp_q;
  logic                out_valid_q;
  logic [1:0]          row_index_q, col_index_q;
  logic [PW-1:0]       row_power_q, col_power_q;
  logic                detected_q;

  // recurrence datapath
  logic signed [CW-1:0]   coeff;
  logic signed [CQ_W-1:0] rprod;
  logic signed [CQ_W-1:0] rshr;
  logic [A-1:0]           q0;
  logic [CNT_W-1:0]       cnt_next;
  logic [CMP_W-1:0]       blen_ext, len_eff;
  logic                   block_end;

  // power datapath
  logic [A-1:0]           m1, m2;
  logic [CW-1:0]          mc;
  logic [PROD_W+7:0]      pp;
  logic [PROD_W-1:0]      acc_next;
  logic [SW-1:0]          t_ext, t_shr, p_full;
  logic [PW-1:0]          p_sat;
  logic [PW-1:0]          pmax;
  logic [KP_W-1:0]        pur_lhs;
  logic                   out_free;
  logic                   emit;

  assign coeff    = gdd_pkg::coeff_of(cfg_i.row_coeffs, cfg_i.col_coeffs, bin_q);
  assign rprod    = coeff * $signed(d1_q[bin_q]);
  assign rshr     = rprod >>> FB;
  assign q0       = rshr[A-1:0] - d2_q[bin_q] + x_q;
  assign cnt_next = cnt_q + 1'b1;

  always_comb begin
    blen_ext = CMP_W'(cfg_i.block_length);
    if (blen_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (blen_ext > CMP_W'(MAX_BLOCK_LENGTH)) begin
      len_eff = CMP_W'(MAX_BLOCK_LENGTH);
    end else begin
      len_eff = blen_ext;
    end
  end
  assign block_end = (CMP_W'(cnt_next) >= len_eff);

  assign m1 = d1_q[bin_q][A-1] ? (~d1_q[bin_q] + 1'b1) : d1_q[bin_q];
  assign m2 = d2_q[bin_q][A-1] ? (~d2_q[bin_q] + 1'b1) : d2_q[bin_q];
  assign mc = coeff[CW-1] ? (~coeff + 1'b1) : coeff;

  assign pp       = mul_a_q * mul_b_q[7:0];
  assign acc_next = acc_q + pp[PROD_W-1:0];

  always_comb begin
    t_ext = SW'(t_q);
    t_shr = t_ext >> FB;
    if (!neg_q) begin
      p_full = (s_q < t_shr) ? '0 : (s_q - t_shr);
    end else begin
      p_full = s_q + ((t_ext + SW'((1 << FB) - 1)) >> FB);
    end
    p_sat = (|p_full[SW-1:PW]) ? '1 : p_full[PW-1:0];
  end

  assign pmax     = (rp_q > cp_q) ? rp_q : cp_q;
  assign pur_lhs  = KP_W'(pw_q[bin_q]) * KP_W'(gdd_pkg::K_ONE);
  assign out_free = !out_valid_q || result_ready_i;
  assign emit     = (state_q == S_EMIT) && out_free;
  assign q_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bin_q       <= '0;
      ph_q        <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < gdd_pkg::NUM_BINS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            x_q     <= A'($signed(q_sample_i));
            bin_q   <= '0;
            state_q <= S_REC;
          end
        end
        S_REC: begin
          d2_q[bin_q] <= d1_q[bin_q];
          d1_q[bin_q] <= q0;
          bin_q       <= bin_q + 1'b1;
          if (bin_q == 3'd7) begin
            if (block_end) begin
              cnt_q   <= '0;
              rp_q    <= '0;
              cp_q    <= '0;
              ri_q    <= '0;
              ci_q    <= '0;
              state_q <= S_PLD;
            end else begin
              cnt_q   <= cnt_next;
              state_q <= S_IDLE;
            end
          end
        end
        S_PLD: begin
          cq_q    <= mc * m1;
          neg_q   <= coeff[CW-1] ^ d1_q[bin_q][A-1] ^ d2_q[bin_q][A-1];
          m2_q    <= m2;
          mul_a_q <= PROD_W'(m1);
          mul_b_q <= m1;
          acc_q   <= '0;
          step_q  <= '0;
          ph_q    <= 2'd0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (step_q == STEP_W'(NSTEP - 1)) begin
            step_q <= '0;
            acc_q  <= '0;
            case (ph_q)
              2'd0: begin
                s_q     <= SW'(acc_next);
                mul_a_q <= PROD_W'(m2_q);
                mul_b_q <= m2_q;
                ph_q    <= 2'd1;
              end
              2'd1: begin
                s_q     <= s_q + SW'(acc_next);
                mul_a_q <= PROD_W'(cq_q);
                mul_b_q <= m2_q;
                ph_q    <= 2'd2;
              end
              default: begin
                t_q     <= acc_next;
                state_q <= S_FIN;
              end
            endcase
          end else begin
            mul_a_q <= mul_a_q << 8;
            mul_b_q <= mul_b_q >> 8;
            acc_q   <= acc_next;
            step_q  <= step_q + 1'b1;
          end
        end
        S_FIN: begin
          pw_q[bin_q] <= p_sat;
          d1_q[bin_q] <= '0;
          d2_q[bin_q] <= '0;
          if (!bin_q[2]) begin
            if (p_sat > rp_q) begin
              rp_q <= p_sat;
              ri_q <= bin_q[1:0];
            end
          end else begin
            if (p_sat > cp_q) begin
              cp_q <= p_sat;
              ci_q <= bin_q[1:0];
            end
          end
          bin_q   <= bin_q + 1'b1;
          state_q <= (bin_q == 3'd7) ? S_TST1 : S_PLD;
        end
        S_TST1: begin
          a1_q    <= KP_W'(rp_q) * KP_W'(gdd_pkg::K_ONE);
          b1_q    <= KP_W'(cp_q) * KP_W'(gdd_pkg::K_ROW);
          a2_q    <= KP_W'(cp_q) * KP_W'(gdd_pkg::K_ONE);
          b2_q    <= KP_W'(rp_q) * KP_W'(gdd_pkg::K_COL);
          pm_q    <= KP_W'(pmax) * KP_W'(gdd_pkg::K_ROW);
          state_q <= S_TST2;
        end
        S_TST2: begin
          det_q   <= (rp_q > cfg_i.power_threshold) && (cp_q > cfg_i.power_threshold)
                     && (a1_q >= b1_q) && (a2_q >= b2_q);
          imp_q   <= '0;
          bin_q   <= '0;
          state_q <= S_PUR;
        end
        S_PUR: begin
          if (pur_lhs > pm_q) begin
            imp_q <= imp_q + 1'b1;
          end
          bin_q <= bin_q + 1'b1;
          if (bin_q == 3'd7) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            row_index_q <= ri_q;
            col_index_q <= ci_q;
            row_power_q <= rp_q;
            col_power_q <= cp_q;
            detected_q  <= det_q && (imp_q < 4'(gdd_pkg::MAX_IMPURE));
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = out_valid_q;
  assign row_index_o    = row_index_q;
  assign col_index_o    = col_index_q;
  assign row_power_o    = row_power_q;
  assign col_power_o    = col_power_q;
  assign detected_o     = detected_q;

endmodule

`default_nettype wire

// ===== hw/rtl/goertzel_dtmf_detector_core.sv =====
`default_nettype none

// Channel  | valid           | ready           | word
// ---------+-----------------+-----------------+------------------------------------------
// sample   | sample_valid_i  | sample_ready_o  | sample_i
// result   | result_valid_o  | result_ready_i  | row/col_index_o, row/col_power_o, detected_o
// config   | psel & penable  | pready (tied 1) | paddr, pwdata, pwrite -> prdata
//
// Each sample: queue pop (S_IDLE), then all eight bins in turn on the shared recurrence
// multiplier (S_REC). Block end: per bin, S_PLD, S_MUL on the 8-bit-slice power multiplier
// and S_FIN; then twist/purity tests (S_TST1/2, S_PUR) and the output register (S_EMIT).
// A 4-word input queue absorbs samples while the power phase runs.
// Reset clears resonators, sample count, queue and output valid; config resets to defaults.
// The back end stalls only in its final step, until the output register is free.

module goertzel_dtmf_detector_core #(
  parameter int unsigned MAX_BLOCK_LENGTH = gdd_pkg::MAX_BLOCK_LENGTH_DEF,
  parameter int unsigned SAMPLE_WIDTH     = gdd_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned ACCUM_WIDTH      = gdd_pkg::ACCUM_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [4:0]              paddr,
  input  wire logic [63:0]             pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  wire logic                    sample_valid_i,
  output logic                         sample_ready_o,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                         result_valid_o,
  input  wire logic                    result_ready_i,
  output logic [1:0]                   row_index_o,
  output logic [1:0]                   col_index_o,
  output logic [63:0]                  row_power_o,
  output logic [63:0]                  col_power_o,
  output logic                         detected_o
);

  gdd_pkg::cfg_t                    cfg_q;
  logic [gdd_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                             wr_en;
  logic                             q_valid, q_ready;
  logic [SAMPLE_WIDTH-1:0]          q_sample;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_coeffs      <= '0;
      cfg_q.col_coeffs      <= '0;
      cfg_q.block_length    <= gdd_pkg::BLOCK_LEN_RESET;
      cfg_q.power_threshold <= gdd_pkg::POWER_THR_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        gdd_pkg::REG_ROW_COEFFS: cfg_q.row_coeffs      <= pwdata;
        gdd_pkg::REG_COL_COEFFS: cfg_q.col_coeffs      <= pwdata;
        gdd_pkg::REG_BLOCK_LEN:  cfg_q.block_length    <= pwdata[gdd_pkg::BLEN_W-1:0];
        gdd_pkg::REG_POWER_THR:  cfg_q.power_threshold <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gdd_pkg::REG_ROW_COEFFS: prdata = cfg_q.row_coeffs;
      gdd_pkg::REG_COL_COEFFS: prdata = cfg_q.col_coeffs;
      gdd_pkg::REG_BLOCK_LEN:  prdata = 64'(cfg_q.block_length);
      gdd_pkg::REG_POWER_THR:  prdata = cfg_q.power_threshold;
      default:                 prdata = '0;
    endcase
  end

  gdd_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .q_valid_o      (q_valid),
    .q_ready_i      (q_ready),
    .q_sample_o     (q_sample)
  );

  gdd_back #(
    .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .ACCUM_WIDTH      (ACCUM_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .q_sample_i     (q_sample),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .row_index_o    (row_index_o),
    .col_index_o    (col_index_o),
    .row_power_o    (row_power_o),
    .col_power_o    (col_power_o),
    .detected_o     (detected_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gdd_checker.sv =====
`default_nettype none

module gdd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        result_valid_o,
  input wire logic        result_ready_i,
  input wire logic [1:0]  row_index_o,
  input wire logic [1:0]  col_index_o,
  input wire logic [63:0] row_power_o,
  input wire logic [63:0] col_power_o,
  input wire logic        detected_o
);

  // pready is tied high
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // a detection needs both peaks above the threshold, so neither can be zero
  a_det_pow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && detected_o) |-> (row_power_o != 64'd0 && col_power_o != 64'd0))
    else $error("detection with zero peak power");

  // a zero peak implies the index of the first bin
  a_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && row_power_o == 64'd0) |-> (row_index_o == 2'd0))
    else $error("zero row power with nonzero index");

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_ready_i) |=>
      (result_valid_o && $stable(row_index_o) && $stable(col_index_o)
       && $stable(row_power_o) && $stable(col_power_o) && $stable(detected_o)))
    else $error("result word changed while stalled");

endmodule

bind goertzel_dtmf_detector_core gdd_checker u_gdd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready         (pready),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i),
  .row_index_o    (row_index_o),
  .col_index_o    (col_index_o),
  .row_power_o    (row_power_o),
  .col_power_o    (col_power_o),
  .detected_o     (detected_o)
);

`default_nettype wire

// ===== tb/tb_goertzel_dtmf_detector_core.sv =====
`default_nettype none

module tb_goertzel_dtmf_detector_core;

  typedef struct packed {
    logic [1:0]  row_index;
    logic [1:0]  col_index;
    logic [63:0] row_power;
    logic [63:0] col_power;
    logic        detected;
  } tone_word_t;

  localparam logic [63:0] DTMF_ROWS = {16'sd24218, 16'sd25701, 16'sd26956, 16'sd27980};
  localparam logic [63:0] DTMF_COLS = {16'sd9315, 16'sd13085, 16'sd16325, 16'sd19073};
  localparam int DRAIN_CYCLES = 300;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;
  logic        sample_valid, sample_ready;
  logic [15:0] sample;
  logic        result_valid, result_ready;
  logic [1:0]  row_index, col_index;
  logic [63:0] row_power, col_power;
  logic        detected;

  goertzel_dtmf_detector_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_valid_i (sample_valid),
    .sample_ready_o (sample_ready),
    .sample_i       (sample),
    .result_valid_o (result_valid),
    .result_ready_i (result_ready),
    .row_index_o    (row_index),
    .col_index_o    (col_index),
    .row_power_o    (row_power),
    .col_power_o    (col_power),
    .detected_o     (detected)
  );

  // detector shadow state
  logic [63:0]                row_c, col_c, thr;
  logic [gdd_pkg::BLEN_W-1:0] blen;
  logic signed [39:0]         q1 [gdd_pkg::NUM_BINS];
  logic signed [39:0]         q2 [gdd_pkg::NUM_BINS];
  int unsigned                n_in_block;

  tone_word_t tone_words_due [$];
  int  mismatches, words_seen, detections, samples_sent;
  bit  quiet;
  int  hold_left;
  real row_hz [4] = '{697.0, 770.0, 852.0, 941.0};
  real col_hz [4] = '{1209.0, 1336.0, 1477.0, 1633.0};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("timeout, %0d words still due", tone_words_due.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [63:0] bin_power(logic signed [39:0] a, logic signed [39:0] b,
                                            logic signed [15:0] c);
    logic signed [127:0] wa, wb, wc, p;
    wa = a;
    wb = b;
    wc = c;
    p = wa * wa + wb * wb - ((wc * wa * wb) >>> gdd_pkg::FRAC_BITS);
    if (p < 0) p = 0;
    if (p > 128'sh0000_0000_0000_0000_FFFF_FFFF_FFFF_FFFF) p = 128'hFFFF_FFFF_FFFF_FFFF;
    return p[63:0];
  endfunction

  function automatic bit scaled_ge(logic [63:0] a, int ka, logic [63:0] b, int kb);
    logic [127:0] l, r;
    l = {64'b0, a} * ka;
    r = {64'b0, b} * kb;
    return l >= r;
  endfunction

  task automatic predict_sample(input logic [15:0] x);
    logic signed [127:0] acc;
    logic signed [15:0]  c;
    logic [63:0]         pw [gdd_pkg::NUM_BINS];
    logic [63:0]         pmax;
    int unsigned         len, impure;
    tone_word_t          w;
    len = blen == 0 ? 1 : (blen > 1024 ? 1024 : blen);
    for (int i = 0; i < gdd_pkg::NUM_BINS; i++) begin
      c = (i < 4) ? row_c[16*i +: 16] : col_c[16*(i-4) +: 16];
      acc = ((128'(signed'(c)) * 128'(q1[i])) >>> gdd_pkg::FRAC_BITS) - q2[i] + signed'(x);
      q2[i] = q1[i];
      q1[i] = acc[39:0];
    end
    n_in_block++;
    if (n_in_block < len) return;
    for (int i = 0; i < gdd_pkg::NUM_BINS; i++) begin
      c = (i < 4) ? row_c[16*i +: 16] : col_c[16*(i-4) +: 16];
      pw[i] = bin_power(q1[i], q2[i], c);
      q1[i] = '0;
      q2[i] = '0;
    end
    n_in_block = 0;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      if (pw[i] > w.row_power) begin
        w.row_power = pw[i];
        w.row_index = 2'(i);
      end
      if (pw[i+4] > w.col_power) begin
        w.col_power = pw[i+4];
        w.col_index = 2'(i);
      end
    end
    pmax = (w.row_power > w.col_power) ? w.row_power : w.col_power;
    w.detected = w.row_power > thr && w.col_power > thr
        && scaled_ge(w.row_power, gdd_pkg::K_ONE, w.col_power, gdd_pkg::K_ROW)
        && scaled_ge(w.col_power, gdd_pkg::K_ONE, w.row_power, gdd_pkg::K_COL);
    if (w.detected) begin
      impure = 0;
      for (int i = 0; i < gdd_pkg::NUM_BINS; i++)
        if (!scaled_ge(pmax, gdd_pkg::K_ROW, pw[i], gdd_pkg::K_ONE)) impure++;
      w.detected = impure < gdd_pkg::MAX_IMPURE;
    end
    tone_words_due = {tone_words_due, w};
  endtask

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 18);
  endfunction

  // valid stays high on return; any caller that lets time pass lowers it first
  task automatic push_sample(input logic [15:0] x);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid <= 1'b1;
    sample <= x;
    do @(posedge clk_i); while (!sample_ready);
    predict_sample(x);
    samples_sent++;
  endtask

  task automatic apb_write(input logic [gdd_pkg::REG_IDX_W-1:0] idx, input logic [63:0] v);
    logic [63:0] exp_rd;
    exp_rd = (idx == gdd_pkg::REG_BLOCK_LEN) ? 64'(v[gdd_pkg::BLEN_W-1:0]) : v;
    sample_valid <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      gdd_pkg::REG_ROW_COEFFS: row_c = v;
      gdd_pkg::REG_COL_COEFFS: col_c = v;
      gdd_pkg::REG_BLOCK_LEN:  blen = v[gdd_pkg::BLEN_W-1:0];
      gdd_pkg::REG_POWER_THR:  thr = v;
      default: ;
    endcase
    @(posedge clk_i);
    if (!pready || prdata !== exp_rd) begin
      mismatches++;
      if (mismatches <= 10) $display("register %0d read back: expected %h, got %h",
                                     idx, exp_rd, prdata);
    end
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk_i);
    while (tone_words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] tone_sample(int n, int ri, int ci, real ar, real ac,
                                              int noise);
    real v;
    int  k;
    v = ar * $sin(6.283185307 * row_hz[ri] * n / 8000.0)
      + ac * $sin(6.283185307 * col_hz[ci] * n / 8000.0);
    if (noise > 0) v = v + $itor($urandom_range(0, 2 * noise)) - noise;
    k = $rtoi(v);
    if (k > 32767) k = 32767;
    if (k < -32768) k = -32768;
    return k[15:0];
  endfunction

  // receiver: per-word random stall plus an optional long hold-off
  initial begin
    int stall;
    stall = 0;
    result_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (result_valid && result_ready) stall = draw_gap();
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    tone_word_t e, a;
    if (rst_ni && result_valid && result_ready) begin
      a = '{row_index, col_index, row_power, col_power, detected};
      words_seen++;
      if (tone_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", a);
      end else begin
        e = tone_words_due.pop_front();
        if (a.detected) detections++;
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("word %0d mismatch: expected %p, got %p",
                                         words_seen, e, a);
        end
      end
    end
  end

  task automatic test_extremes();
    apb_write(gdd_pkg::REG_ROW_COEFFS, 64'h7FFF_7FFF_7FFF_7FFF);
    apb_write(gdd_pkg::REG_COL_COEFFS, 64'h8000_8000_8000_8000);
    apb_write(gdd_pkg::REG_BLOCK_LEN, 64'd4);
    apb_write(gdd_pkg::REG_POWER_THR, 64'd0);
    repeat (4) push_sample(16'h7FFF);
    repeat (4) push_sample(16'h8000);
    repeat (4) push_sample(16'h0000);
    drain();
    apb_write(gdd_pkg::REG_ROW_COEFFS, 64'h0001_8001_4000_0000);
    apb_write(gdd_pkg::REG_COL_COEFFS, 64'hC000_7FFF_0000_FFFF);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    drain();
  endtask

  task automatic test_long_block();
    apb_write(gdd_pkg::REG_ROW_COEFFS, 64'h7FFF_7FFF_7FFF_7FFF);
    apb_write(gdd_pkg::REG_COL_COEFFS, 64'h8000_7FFF_8000_7FFF);
    apb_write(gdd_pkg::REG_BLOCK_LEN, 64'h7FF);
    apb_write(gdd_pkg::REG_POWER_THR, 64'd0);
    quiet = 1;
    repeat (150) push_sample(16'h7FFF);
    quiet = 0;
    drain();
    // shorten the block below the running count: next sample closes it
    apb_write(gdd_pkg::REG_BLOCK_LEN, 64'd1);
    push_sample(16'h7FFF);
    drain();
  endtask

  task automatic test_dtmf_detect();
    apb_write(gdd_pkg::REG_ROW_COEFFS, DTMF_ROWS);
    apb_write(gdd_pkg::REG_COL_COEFFS, DTMF_COLS);
    apb_write(gdd_pkg::REG_BLOCK_LEN, 64'd205);
    apb_write(gdd_pkg::REG_POWER_THR, gdd_pkg::POWER_THR_RESET);
    quiet = 1;
    for (int n = 0; n < 205; n++) push_sample(tone_sample(n, 1, 2, 8000.0, 9000.0, 0));
    quiet = 0;
    drain();
  endtask

  task automatic test_block_length_edges();
    apb_write(gdd_pkg::REG_BLOCK_LEN, 64'd0);
    repeat (3) push_sample(16'($urandom));
    drain();
    apb_write(gdd_pkg::REG_BLOCK_LEN, 64'd1);
    repeat (3) push_sample(16'($urandom));
    drain();
    apb_write(gdd_pkg::REG_BLOCK_LEN, 64'd40);
    repeat (15) push_sample(16'($urandom));
    drain();
    apb_write(gdd_pkg::REG_BLOCK_LEN, 64'd8);
    push_sample(16'($urandom));
    drain();
  endtask

  task automatic test_backpressure();
    apb_write(gdd_pkg::REG_BLOCK_LEN, 64'd1);
    hold_left = 3000;
    quiet = 1;
    repeat (12) push_sample(16'($urandom));
    quiet = 0;
    drain();
  endtask

  task automatic test_random();
    int base, ri, ci, len, kind, noise;
    real ar, ac;
    base = samples_sent;
    while (samples_sent - base < 200) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(2, 30);
      if ($urandom_range(0, 3) == 0) begin
        apb_write(gdd_pkg::REG_ROW_COEFFS, {$urandom, $urandom});
        apb_write(gdd_pkg::REG_COL_COEFFS, {$urandom, $urandom});
      end else begin
        apb_write(gdd_pkg::REG_ROW_COEFFS, DTMF_ROWS);
        apb_write(gdd_pkg::REG_COL_COEFFS, DTMF_COLS);
      end
      apb_write(gdd_pkg::REG_BLOCK_LEN, 64'(len));
      case ($urandom_range(0, 3))
        0: apb_write(gdd_pkg::REG_POWER_THR, 64'd0);
        1: apb_write(gdd_pkg::REG_POWER_THR, {32'b0, $urandom});
        2: apb_write(gdd_pkg::REG_POWER_THR, gdd_pkg::POWER_THR_RESET);
        default: apb_write(gdd_pkg::REG_POWER_THR, 64'hFFFF_FFFF_FFFF_FFFF);
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 9);
        ri = $urandom_range(0, 3);
        ci = $urandom_range(0, 3);
        ar = $urandom_range(200, 16000);
        ac = ar * $urandom_range(30, 300) / 100.0;
        noise = $urandom_range(0, 2000);
        for (int n = 0; n < len; n++) begin
          if (kind < 7) push_sample(tone_sample(n, ri, ci, ar, ac, noise));
          else push_sample(16'($urandom));
        end
      end
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_valid = 1'b0;
    sample = '0;
    hold_left = 0;
    quiet = 0;
    row_c = '0;
    col_c = '0;
    blen = gdd_pkg::BLOCK_LEN_RESET;
    thr = gdd_pkg::POWER_THR_RESET;
    n_in_block = 0;
    for (int i = 0; i < gdd_pkg::NUM_BINS; i++) begin
      q1[i] = '0;
      q2[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    test_extremes();
    test_block_length_edges();
    test_dtmf_detect();
    test_long_block();
    test_backpressure();
    test_random();
    drain();

    $display("%0d samples sent, %0d words checked, %0d tone pairs detected",
             samples_sent, words_seen, detections);
    $display("covered sample/coeff extremes, block length limits, long blocks, backpressure");
    if (mismatches == 0 && tone_words_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d words never seen", mismatches, tone_words_due.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
